// ----- rtl/core/length_field_frame_deframer_assert.svh -----
// Assertion macros used by the length-field deframer core (lffd_core).
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef LENGTH_FIELD_FRAME_DEFRAMER_ASSERT_SVH
`define LENGTH_FIELD_FRAME_DEFRAMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LFFD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");
`define LFFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");
`else
`define LFFD_ASSERT_NOW(lbl, ante, cons)
`define LFFD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/lffd_pkg.sv -----
// Types and constants of the length-field deframer.
// No dependencies.
`timescale 1ns / 1ps

package lffd_pkg;

	localparam int unsigned MAX_HEADER_BYTES = 64;
	localparam logic [2:0] FIELD_BYTES_NARROW = 3'd2;
	localparam logic [2:0] FIELD_BYTES_WIDE = 3'd4;

	localparam logic [1:0] REG_HEADER_SIZE = 2'd0;
	localparam logic [1:0] REG_LENGTH_OFFSET = 2'd1;
	localparam logic [1:0] REG_LEN_FIELD_WIDE = 2'd2;
	localparam logic [1:0] REG_MAX_BODY_SIZE = 2'd3;

	typedef struct packed {
		logic [6:0]  header_size;
		logic [5:0]  length_offset;
		logic        len_field_wide;
		logic [31:0] max_body_size;
	} lffd_cfg_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_header;
		logic        frame_last;
		logic [31:0] body_length;
		logic        too_large;
	} lffd_res_t;

endpackage

// ----- rtl/core/lffd_cfg.sv -----
// Configuration register file of the length-field deframer.
// Depends on lffd_pkg.
`timescale 1ns / 1ps

module lffd_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	output lffd_pkg::lffd_cfg_t cfg
);
	import lffd_pkg::*;

	lffd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_size <= 7'd8;
			cfg_q.length_offset <= 6'd0;
			cfg_q.len_field_wide <= 1'b0;
			cfg_q.max_body_size <= 32'd65535;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER_SIZE: cfg_q.header_size <= cfg_wdata[6:0];
				REG_LENGTH_OFFSET: cfg_q.length_offset <= cfg_wdata[5:0];
				REG_LEN_FIELD_WIDE: cfg_q.len_field_wide <= cfg_wdata[0];
				REG_MAX_BODY_SIZE: cfg_q.max_body_size <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/lffd_core.sv -----
// Frame tracking state and per-byte decode of the length-field deframer.
// Depends on lffd_pkg and length_field_frame_deframer_assert.svh.
`timescale 1ns / 1ps
`include "length_field_frame_deframer_assert.svh"

module lffd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  lffd_pkg::lffd_cfg_t cfg,
	input  logic                take,
	input  logic [7:0]          data_byte,
	output lffd_pkg::lffd_res_t res
);
	import lffd_pkg::*;

	logic [6:0]  header_count_q;
	logic [31:0] body_count_q;
	logic [31:0] length_q;
	logic        in_body_q;
	logic        err_q;

	logic [6:0]  header_count_d;
	logic [31:0] body_count_d;
	logic [31:0] length_d;
	logic        in_body_d;
	logic        err_d;

	logic [6:0]  hs;
	logic [2:0]  flen;
	logic [6:0]  fend;
	logic [6:0]  over;
	logic [2:0]  missing;
	logic        in_field;
	logic        hdr_done;
	logic [31:0] lv_shift;
	logic [31:0] lv_fix;
	logic [31:0] body_next;

	always_comb begin
		if (cfg.header_size == 7'd0) begin
			hs = 7'd1;
		end else if (cfg.header_size > 7'(MAX_HEADER_BYTES)) begin
			hs = 7'(MAX_HEADER_BYTES);
		end else begin
			hs = cfg.header_size;
		end
		flen = cfg.len_field_wide ? FIELD_BYTES_WIDE : FIELD_BYTES_NARROW;
		fend = {1'b0, cfg.length_offset} + {4'b0, flen};
		in_field = (header_count_q >= {1'b0, cfg.length_offset}) && (header_count_q < fend);
		hdr_done = ({1'b0, header_count_q} + 8'd1) >= {1'b0, hs};
		lv_shift = in_field ? {length_q[23:0], data_byte} : length_q;

		// Field bytes that fall beyond the header count as zeros.
		over = fend - hs;
		if (fend > hs) begin
			missing = (over > {4'b0, flen}) ? flen : over[2:0];
		end else begin
			missing = 3'd0;
		end
		case (missing)
			3'd1: lv_fix = {lv_shift[23:0], 8'h00};
			3'd2: lv_fix = {lv_shift[15:0], 16'h0000};
			3'd3: lv_fix = {lv_shift[7:0], 24'h000000};
			3'd4: lv_fix = 32'd0;
			default: lv_fix = lv_shift;
		endcase
		body_next = body_count_q + 32'd1;

		header_count_d = header_count_q;
		body_count_d = body_count_q;
		length_d = length_q;
		in_body_d = in_body_q;
		err_d = err_q;
		res.out_byte = data_byte;
		res.is_header = 1'b0;
		res.frame_last = 1'b0;
		res.body_length = length_q;

		if (err_q) begin
			// Sticky error: bytes pass through and state is frozen.
		end else if (!in_body_q) begin
			res.is_header = 1'b1;
			res.body_length = 32'd0;
			if (hdr_done) begin
				length_d = lv_fix;
				res.body_length = lv_fix;
				if (lv_fix > cfg.max_body_size) begin
					err_d = 1'b1;
				end else if (lv_fix == 32'd0) begin
					res.frame_last = 1'b1;
					header_count_d = 7'd0;
					body_count_d = 32'd0;
					in_body_d = 1'b0;
				end else begin
					in_body_d = 1'b1;
					body_count_d = 32'd0;
					header_count_d = hs;
				end
			end else begin
				length_d = lv_shift;
				header_count_d = header_count_q + 7'd1;
			end
		end else begin
			body_count_d = body_next;
			if (body_next >= length_q) begin
				res.frame_last = 1'b1;
				header_count_d = 7'd0;
				body_count_d = 32'd0;
				length_d = 32'd0;
				in_body_d = 1'b0;
			end
		end
		res.too_large = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= 7'd0;
			body_count_q <= 32'd0;
			length_q <= 32'd0;
			in_body_q <= 1'b0;
			err_q <= 1'b0;
		end else if (take) begin
			header_count_q <= header_count_d;
			body_count_q <= body_count_d;
			length_q <= length_d;
			in_body_q <= in_body_d;
			err_q <= err_d;
		end
	end

	`LFFD_ASSERT_NEXT(a_err_sticky, err_q, err_q)
	`LFFD_ASSERT_NOW(a_body_len_nonzero, in_body_q, length_q != 32'd0)
	`LFFD_ASSERT_NOW(a_err_not_in_body, err_q, !in_body_q)
	`LFFD_ASSERT_NOW(a_last_no_err, take && res.frame_last, !res.too_large)

endmodule

// ----- rtl/core/length_field_frame_deframer.sv -----
// Top level of the length-field deframer: input stage, output register, wiring.
// Depends on lffd_pkg, lffd_cfg and lffd_core.
//
//   channel  | direction | signals                         | contents
//   s_*      | in        | s_tvalid s_tready s_tdata       | one stream byte per item
//   m_*      | out       | m_tvalid m_tready m_tdata/tlast/tuser | tagged byte per item
//   cfg_*    | in        | cfg_we cfg_index cfg_wdata      | register writes
//
// One item per clock while m_tready holds high; each item passes the input register,
// then is decoded into the result register.
// The decode of a byte needs only the frame state left by the previous byte.
// Reset clears the frame state, the sticky error and both stages, and loads the
// register defaults. A stalled output holds its result while one more item waits
// in the input register.
`timescale 1ns / 1ps

module length_field_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [7:0] out_byte, [39:8] body_length
	output logic        m_tlast,  // frame_last
	output logic [1:0]  m_tuser,  // [0] is_header, [1] too_large
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import lffd_pkg::*;

	lffd_cfg_t cfg;
	lffd_res_t res;
	lffd_res_t res_q;
	logic      valid_s1;
	logic [7:0] byte_s1;
	logic      out_valid_q;
	logic      adv;

	assign adv = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
		if (adv) begin
			res_q <= res;
		end
	end

	lffd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lffd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.take      (adv),
		.data_byte (byte_s1),
		.res       (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata = {res_q.body_length, res_q.out_byte};
	assign m_tlast = res_q.frame_last;
	assign m_tuser = {res_q.too_large, res_q.is_header};

endmodule

// ----- test/length_field_frame_deframer_tb.sv -----
// Self-checking testbench for the length-field frame deframer.
// Depends on lffd_pkg and the length_field_frame_deframer RTL; reads no files.
`timescale 1ns / 1ps

module length_field_frame_deframer_tb;

	import lffd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned IDLE_PCT = 17;

	// Tracks the framing state and the queue of tagged bytes that should come out.
	class frame_tag_scoreboard;
		logic [6:0]  hdr_size_reg;
		logic [5:0]  len_off_reg;
		logic        wide_len_reg;
		logic [31:0] max_body_reg;
		logic [6:0]  hdr_pos;
		logic [31:0] body_pos;
		logic [31:0] len_acc;
		bit          in_body;
		bit          overflow;
		lffd_res_t   tags_due[$];
		int unsigned mismatches;
		int unsigned checked;

		function new();
			hdr_size_reg = 7'd8;
			len_off_reg = 6'd0;
			wide_len_reg = 1'b0;
			max_body_reg = 32'd65535;
			restart_frame();
			overflow = 1'b0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void restart_frame();
			hdr_pos = '0;
			body_pos = '0;
			len_acc = '0;
			in_body = 1'b0;
		endfunction

		function void set_reg(logic [1:0] index, logic [31:0] value);
			case (index)
				REG_HEADER_SIZE: hdr_size_reg = value[6:0];
				REG_LENGTH_OFFSET: len_off_reg = value[5:0];
				REG_LEN_FIELD_WIDE: wide_len_reg = value[0];
				REG_MAX_BODY_SIZE: max_body_reg = value;
				default: ;
			endcase
		endfunction

		// Works out the tag of one accepted byte and advances the framing state.
		function void predict_tag(logic [7:0] b);
			lffd_res_t   tag;
			int unsigned hs;
			int unsigned flen;
			int unsigned pos;
			int unsigned field_end;
			int unsigned miss;
			logic [63:0] v;
			tag = '0;
			tag.out_byte = b;
			if (overflow) begin
				tag.body_length = len_acc;
			end else if (!in_body) begin
				hs = 32'(hdr_size_reg);
				if (hs == 0) hs = 1;
				if (hs > MAX_HEADER_BYTES) hs = MAX_HEADER_BYTES;
				flen = 32'(wide_len_reg ? FIELD_BYTES_WIDE : FIELD_BYTES_NARROW);
				pos = 32'(hdr_pos);
				tag.is_header = 1'b1;
				if (pos >= 32'(len_off_reg) && pos < 32'(len_off_reg) + flen)
					len_acc = {len_acc[23:0], b};
				if (pos + 1 >= hs) begin
					// Field bytes that fall past the header count as zeros.
					field_end = 32'(len_off_reg) + flen;
					v = {32'd0, len_acc};
					if (field_end > hs) begin
						miss = field_end - hs;
						if (miss > flen) miss = flen;
						v = (v << (8 * miss)) & 64'hFFFF_FFFF;
					end
					len_acc = v[31:0];
					tag.body_length = len_acc;
					if (len_acc > max_body_reg) begin
						overflow = 1'b1;
					end else if (len_acc == 0) begin
						tag.frame_last = 1'b1;
						restart_frame();
					end else begin
						in_body = 1'b1;
						body_pos = '0;
						hdr_pos = hs[6:0];
					end
				end else begin
					hdr_pos = pos[6:0] + 7'd1;
				end
			end else begin
				tag.body_length = len_acc;
				body_pos++;
				if (body_pos >= len_acc) begin
					tag.frame_last = 1'b1;
					restart_frame();
				end
			end
			tag.too_large = overflow;
			tags_due.insert(tags_due.size(), tag);
		endfunction

		function void check_tag(logic [39:0] data, logic last, logic [1:0] user);
			lffd_res_t want;
			lffd_res_t got;
			got.out_byte = data[7:0];
			got.body_length = data[39:8];
			got.frame_last = last;
			got.is_header = user[0];
			got.too_large = user[1];
			checked++;
			if (tags_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected tag: byte %h hdr %b last %b len %h big %b",
						got.out_byte, got.is_header, got.frame_last, got.body_length,
						got.too_large);
				return;
			end
			want = tags_due[0];
			tags_due.delete(0);
			if (got.out_byte !== want.out_byte || got.is_header !== want.is_header ||
					got.frame_last !== want.frame_last ||
					got.body_length !== want.body_length ||
					got.too_large !== want.too_large) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"tag %0d wrong: want byte %h hdr %b last %b len %h big %b, ",
						"got byte %h hdr %b last %b len %h big %b"}, checked,
						want.out_byte, want.is_header, want.frame_last, want.body_length,
						want.too_large, got.out_byte, got.is_header, got.frame_last,
						got.body_length, got.too_large);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	frame_tag_scoreboard board = new();
	int unsigned sent = 0;
	int unsigned cycles = 0;
	bit steady = 1'b0;

	length_field_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.predict_tag(b);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.tags_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		board.set_reg(index, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reconfigure(input logic [6:0] hs, input logic [5:0] off,
			input logic wide, input logic [31:0] lim);
		drain();
		write_reg(REG_HEADER_SIZE, 32'(hs));
		write_reg(REG_LENGTH_OFFSET, 32'(off));
		write_reg(REG_LEN_FIELD_WIDE, 32'(wide));
		write_reg(REG_MAX_BODY_SIZE, lim);
	endtask

	// Sends the rest of the current header with the length encoded in the field
	// position, then body bytes until the frame closes, as the framing state says.
	task automatic send_frame(input logic [31:0] len);
		int unsigned pos;
		int unsigned k;
		int unsigned flen;
		logic [7:0] b;
		flen = 32'(board.wide_len_reg ? FIELD_BYTES_WIDE : FIELD_BYTES_NARROW);
		do begin
			pos = 32'(board.hdr_pos);
			b = 8'($urandom_range(255));
			if (pos >= 32'(board.len_off_reg) && pos < 32'(board.len_off_reg) + flen) begin
				k = flen - 1 - (pos - 32'(board.len_off_reg));
				b = 8'(len >> (8 * k));
			end
			push_byte(b);
		end while (board.hdr_pos != 7'd0 && !board.in_body && !board.overflow);
		while (board.in_body && !board.overflow) push_byte(8'($urandom_range(255)));
	endtask

	initial begin : take_results
		int unsigned hold_left;
		bit hold_done;
		bit rdy;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_tag(m_tdata, m_tlast, m_tuser);
			// One long hold-off lets the block back up into its input.
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (!hold_done && board.checked >= 600) begin
				hold_done = 1'b1;
				hold_left = 150;
				rdy = 1'b0;
			end else begin
				rdy = steady || ($urandom_range(99) >= IDLE_PCT);
			end
			m_tready <= rdy;
		end
	end

	initial begin : feed_bytes
		logic [7:0] opening[19];
		int unsigned hs;
		int unsigned off;
		int unsigned wide;
		int unsigned lim;
		int unsigned target;
		int unsigned sub;
		int unsigned r;
		logic [31:0] len;
		opening = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h00, 8'h03, 8'h00, 8'hAA, 8'h55, 8'hFF, 8'h80, 8'h01,
			8'h00, 8'hFF, 8'h7F};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Register defaults: an empty frame, then a three-byte body.
		foreach (opening[i]) push_byte(opening[i]);
		repeat (12) send_frame($urandom_range(20));

		// One-byte header with a two-byte field: the low field byte reads as zero.
		reconfigure(7'd1, 6'd0, 1'b0, 32'd65535);
		send_frame(32'h0000_0100);
		repeat (30) send_frame($urandom_range(255));

		// Header size zero acts as one.
		reconfigure(7'd0, 6'd0, 1'b1, 32'd65535);
		repeat (30) send_frame($urandom_range(255));

		// Oversized header setting clamps to the largest header.
		reconfigure(7'd127, 6'd62, 1'b0, 32'hFFFF_FFFF);
		send_frame(32'd0);
		send_frame(32'd1);
		send_frame(32'd30);
		reconfigure(7'd64, 6'd60, 1'b1, 32'hFFFF_FFFF);
		send_frame(32'd17);
		send_frame(32'd0);

		// Shrink the header and raise the limit while a header is half taken.
		reconfigure(7'd16, 6'd0, 1'b0, 32'd3);
		push_byte(8'h00);
		push_byte(8'h07);
		repeat (3) push_byte(8'($urandom_range(255)));
		drain();
		write_reg(REG_HEADER_SIZE, 32'd4);
		write_reg(REG_MAX_BODY_SIZE, 32'd40);
		send_frame(32'd7);
		send_frame(32'd40);

		// Field partly and wholly beyond the header.
		reconfigure(7'd3, 6'd2, 1'b0, 32'd65535);
		repeat (15) send_frame($urandom_range(255));
		reconfigure(7'd2, 6'd5, 1'b1, 32'd65535);
		repeat (10) send_frame($urandom_range(255));

		// No body allowed at all.
		reconfigure(7'd6, 6'd1, 1'b1, 32'd0);
		repeat (10) send_frame(32'd0);

		sub = 0;
		while (sent < 1480) begin
			hs = $urandom_range(12, 1);
			wide = $urandom_range(1);
			off = (hs >= (wide ? 4 : 2)) ? $urandom_range(hs - (wide ? 4 : 2)) : 0;
			lim = $urandom_range(100, 20);
			reconfigure(7'(hs), 6'(off), 1'(wide), lim);
			steady = (sub == 1);
			target = sent + 120;
			while (sent < target) begin
				r = $urandom_range(99);
				if (r < 10) len = 0;
				else if (r < 16) len = lim;
				else len = $urandom_range(30);
				send_frame(len);
			end
			sub++;
		end
		steady = 1'b0;

		// The sticky error ends the run, since only reset clears it.
		reconfigure(7'd8, 6'd3, 1'b1, 32'hFFFF_FFFE);
		send_frame(32'hFFFF_FFFF);
		repeat (25) push_byte(8'($urandom_range(255)));

		drain();
		repeat (6) @(posedge clk);
		if (board.mismatches == 0 && board.tags_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
